FILE: hw/rtl/cst_pkg.sv
// Package for the comment strip token spacer: item types, byte codes and the per-byte scan function.
`default_nettype none
package cst_pkg;

  localparam int unsigned MAX_RES = 7;
  localparam int unsigned CNT_W   = 3;

  // Comment scanner modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_LINE   = 2'd1;
  localparam logic [1:0] MODE_BLOCK  = 2'd2;

  // Byte codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_HASH   = 8'h23;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_end;
  } out_t;

  // One queued result; run_last is added when it leaves the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       text_end;
  } ent_t;

  typedef ent_t [MAX_RES-1:0] ent_list_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       skip;
  } scan_st_t;

  // Result of processing one byte: new scan state and up to three bytes
  typedef struct packed {
    scan_st_t        st;
    logic [1:0]      n;
    logic [2:0][7:0] ch;
  } hb_res_t;

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
           (c == CH_RBRACK) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
           (c == CH_SEMI)   || (c == CH_COLON)  || (c == CH_EQUAL)  ||
           (c == CH_HASH);
  endfunction

  function automatic hb_res_t handle_byte(scan_st_t st, logic [7:0] cur,
                                          logic has_next, logic [7:0] nxt);
    hb_res_t r;
    r    = '0;
    r.st = st;
    if (st.skip) begin
      // second half of a comment opener or closer
      r.st.skip = 1'b0;
    end else if (st.mode == MODE_LINE) begin
      if (cur == CH_NL) begin
        r.st.mode = MODE_NORMAL;
      end
    end else if (st.mode != MODE_NORMAL) begin
      if ((cur == CH_STAR) && has_next && (nxt == CH_SLASH)) begin
        r.st.mode = MODE_NORMAL;
        r.st.skip = 1'b1;
      end
    end else begin
      case (cur)
        CH_SPACE: begin
          if (!has_next || (nxt != CH_SPACE)) begin
            r.n     = 2'd1;
            r.ch[0] = cur;
          end
        end
        CH_NL, CH_TAB: begin
          r.n = 2'd0;
        end
        CH_SLASH: begin
          if (has_next && (nxt == CH_SLASH)) begin
            r.st.mode = MODE_LINE;
            r.st.skip = 1'b1;
          end else if (has_next && (nxt == CH_STAR)) begin
            r.st.mode = MODE_BLOCK;
            r.st.skip = 1'b1;
          end else begin
            r.n     = 2'd1;
            r.ch[0] = cur;
          end
        end
        default: begin
          if (is_delim(cur)) begin
            r.n     = 2'd3;
            r.ch[0] = CH_SPACE;
            r.ch[1] = cur;
            r.ch[2] = CH_SPACE;
          end else begin
            r.n     = 2'd1;
            r.ch[0] = cur;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cst_decode.sv
// Combinational decode of one item against the held byte: result list and next scan state.
`default_nettype none
module cst_decode (
  input  wire cst_pkg::in_t       item,
  input  wire logic [7:0]         held_byte,
  input  wire logic               held_present,
  input  wire cst_pkg::scan_st_t  st,
  output cst_pkg::ent_list_t      list,
  output logic [cst_pkg::CNT_W-1:0] cnt,
  output logic [7:0]              held_byte_nxt,
  output logic                    held_present_nxt,
  output cst_pkg::scan_st_t       st_nxt
);
  import cst_pkg::*;

  hb_res_t          res_a;
  hb_res_t          res_b;
  logic [CNT_W-1:0] n_a;
  logic [CNT_W-1:0] n_b;

  // Held byte with the incoming byte as lookahead, then the final byte alone
  always_comb begin
    res_a    = '0;
    res_a.st = st;
    if (held_present) begin
      res_a = handle_byte(st, held_byte, 1'b1, item.in_char);
    end
    res_b    = '0;
    res_b.st = res_a.st;
    if (item.is_last) begin
      res_b = handle_byte(res_a.st, item.in_char, 1'b0, 8'h00);
    end
  end

  assign n_a = {1'b0, res_a.n};
  assign n_b = {1'b0, res_b.n};

  // Pack the results into one ordered list
  always_comb begin
    list = '0;
    for (int i = 0; i < 3; i++) begin
      if (CNT_W'(i) < n_a) begin
        list[i].ch         = res_a.ch[i];
        list[i].char_valid = 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (CNT_W'(k) < n_b) begin
        list[n_a + CNT_W'(k)].ch         = res_b.ch[k];
        list[n_a + CNT_W'(k)].char_valid = 1'b1;
      end
    end
    if (item.is_last) begin
      list[n_a + n_b].text_end = 1'b1;
    end
    cnt = n_a + n_b + CNT_W'(item.is_last);
  end

  // Next held byte and scan state; end of text returns everything to reset
  always_comb begin
    if (item.is_last) begin
      held_byte_nxt    = 8'h00;
      held_present_nxt = 1'b0;
      st_nxt           = '0;
    end else begin
      held_byte_nxt    = item.in_char;
      held_present_nxt = 1'b1;
      st_nxt           = res_a.st;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cst_emit.sv
// Result queue and output register: sends the list one item per cycle unless stalled.
`default_nettype none
module cst_emit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire cst_pkg::ent_list_t      list,
  input  wire logic [cst_pkg::CNT_W-1:0] cnt,
  output logic                         room,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output cst_pkg::out_t                out_data
);
  import cst_pkg::*;

  ent_list_t        list_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic             out_vld_r;
  out_t             out_data_r;
  logic             out_free;
  logic             take;
  logic [CNT_W-1:0] idx_inc;

  assign out_free = !out_vld_r || out_ready;
  assign take     = out_free && (idx_r != cnt_r);
  assign idx_inc  = idx_r + CNT_W'(1);
  // New list may load once the last queued entry leaves this cycle
  assign room     = (idx_r == cnt_r) || ((idx_inc == cnt_r) && out_free);

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = idx_inc;
    end
  end

  // Queue registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= cnt;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list_r <= list;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.out_char   <= list_r[idx_r].ch;
      out_data_r.char_valid <= list_r[idx_r].char_valid;
      out_data_r.text_end   <= list_r[idx_r].text_end;
      out_data_r.run_last   <= (idx_inc == cnt_r);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/comment_strip_token_spacer.sv
// Top level of the comment strip token spacer.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one source byte per item
//   (in_char) and is_last on the final byte of a text. Output channel
//   out_valid/out_ready/out_data gives zero to seven result items per input
//   item; run_last marks the last result caused by an input item, and an
//   item with char_valid low and text_end high closes each text.
//   Results of an input item go through the result queue and the output
//   register, then follow one per cycle while the receiver takes them.
//   Throughput: one input item per cycle while each item causes at most one
//   result and the receiver does not stall; an item causing more results
//   holds the input until the single output register drains the queue.
//   The first byte of a text, unless it is also its last, is only held and
//   causes no result. Reset (rst_n low, synchronous) clears the held byte,
//   comment mode and queue; no clearing pass is needed.
//   When the receiver stalls, the output register holds its item and the
//   input stalls once the queue has no room for the next item's results.
`default_nettype none
module comment_strip_token_spacer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cst_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cst_pkg::out_t      out_data
);
  import cst_pkg::*;

  logic [7:0]       held_byte_r;
  logic [7:0]       held_byte_nxt;
  logic             held_present_r;
  logic             held_present_nxt;
  scan_st_t         st_r;
  scan_st_t         st_nxt;
  ent_list_t        list;
  logic [CNT_W-1:0] cnt;
  logic             room;
  logic             accept;

  assign in_ready = room;
  assign accept   = in_valid && room;

  cst_decode u_decode (
    .item             (in_data),
    .held_byte        (held_byte_r),
    .held_present     (held_present_r),
    .st               (st_r),
    .list             (list),
    .cnt              (cnt),
    .held_byte_nxt    (held_byte_nxt),
    .held_present_nxt (held_present_nxt),
    .st_nxt           (st_nxt)
  );

  // Lookahead and comment scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r    <= 8'h00;
      held_present_r <= 1'b0;
      st_r           <= '0;
    end else if (accept) begin
      held_byte_r    <= held_byte_nxt;
      held_present_r <= held_present_nxt;
      st_r           <= st_nxt;
    end
  end

  cst_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .list      (list),
    .cnt       (cnt),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for comment_strip_token_spacer: random and directed source text.
module tb_top;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TEXT_ITEMS  = 195;

  typedef bit [7:0] text_t[$];

  // Predicts the stripped and padded byte stream and checks it in order
  class strip_scoreboard;
    localparam int MAX_SHOWN = 10;

    bit [7:0] held;
    bit       held_ok;
    bit [1:0] mode;
    bit       skip;
    out_t     exp_bytes[$];
    out_t     step_res[$];
    int       errors;

    function void clear_text();
      held    = 8'h00;
      held_ok = 1'b0;
      mode    = MODE_NORMAL;
      skip    = 1'b0;
    endfunction

    function void emit(bit [7:0] ch, bit valid, bit eot);
      out_t r;
      r.out_char   = ch;
      r.char_valid = valid;
      r.run_last   = 1'b0;
      r.text_end   = eot;
      step_res.push_back(r);
    endfunction

    // One byte through the comment scanner; has_nxt low means no lookahead
    function void scan_byte(bit [7:0] cur, bit has_nxt, bit [7:0] nxt);
      bit nxt_slash;
      bit nxt_star;
      nxt_slash = has_nxt && (nxt == CH_SLASH);
      nxt_star  = has_nxt && (nxt == CH_STAR);
      if (skip) begin
        skip = 1'b0;
      end else if (mode == MODE_LINE) begin
        if (cur == CH_NL) mode = MODE_NORMAL;
      end else if (mode != MODE_NORMAL) begin
        // block comment closes only on star followed by slash
        if ((cur == CH_STAR) && nxt_slash) begin
          mode = MODE_NORMAL;
          skip = 1'b1;
        end
      end else if (cur == CH_SPACE) begin
        if (!(has_nxt && (nxt == CH_SPACE))) emit(cur, 1'b1, 1'b0);
      end else if ((cur == CH_NL) || (cur == CH_TAB)) begin
        // dropped
      end else if ((cur == CH_SLASH) && (nxt_slash || nxt_star)) begin
        mode = nxt_slash ? MODE_LINE : MODE_BLOCK;
        skip = 1'b1;
      end else if (cur inside {CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                               CH_RBRACE, CH_SEMI, CH_COLON, CH_EQUAL, CH_HASH}) begin
        emit(CH_SPACE, 1'b1, 1'b0);
        emit(cur, 1'b1, 1'b0);
        emit(CH_SPACE, 1'b1, 1'b0);
      end else begin
        emit(cur, 1'b1, 1'b0);
      end
    endfunction

    function void note_input(in_t d);
      step_res.delete();
      if (held_ok) scan_byte(held, 1'b1, d.in_char);
      held    = d.in_char;
      held_ok = 1'b1;
      if (d.is_last) begin
        scan_byte(d.in_char, 1'b0, 8'h00);
        emit(8'h00, 1'b0, 1'b1);
        clear_text();
      end
      if (step_res.size() > 0) step_res[$].run_last = 1'b1;
      foreach (step_res[i]) exp_bytes.push_back(step_res[i]);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (exp_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected item: char=%h valid=%b last=%b end=%b",
                   got.out_char, got.char_valid, got.run_last, got.text_end);
        return;
      end
      want = exp_bytes.pop_front();
      if ((got.out_char !== want.out_char) || (got.char_valid !== want.char_valid) ||
          (got.run_last !== want.run_last) || (got.text_end !== want.text_end)) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: exp char=%h valid=%b last=%b end=%b,",
                   want.out_char, want.char_valid, want.run_last, want.text_end,
                   " got char=%h valid=%b last=%b end=%b",
                   got.out_char, got.char_valid, got.run_last, got.text_end);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  strip_scoreboard sb = new();
  bit   steady;     // no idling on either side while set
  int   hold_left;
  int   roll;
  int   cycles;
  bit [7:0] delims[10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                           CH_RBRACE, CH_SEMI, CH_COLON, CH_EQUAL, CH_HASH};

  comment_strip_token_spacer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, some long
  always @(negedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else if (roll < 95) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(10, 40);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(bit [7:0] ch, bit last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.in_char = ch;
    in_data.is_last = last;
    in_valid        = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(in_data);
  endtask

  task automatic send_text(text_t t);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  // Sender holds off until every expected item has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.exp_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic text_t to_text(string s);
    text_t t;
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  function automatic bit [7:0] filler();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return CH_STAR;
    if (r < 3) return CH_SLASH;
    if (r < 4) return CH_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Random text: mostly tokens and well-formed comments, some noise
  function automatic text_t make_text();
    text_t t;
    int goal;
    int kind;
    int n;
    goal = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
    while (t.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        n = $urandom_range(1, 4);
        repeat (n) t.push_back(8'h61 + 8'($urandom_range(0, 25)));
      end else if (kind < 40) begin
        n = $urandom_range(1, 3);
        repeat (n) t.push_back(CH_SPACE);
      end else if (kind < 55) begin
        t.push_back(delims[$urandom_range(0, 9)]);
      end else if (kind < 65) begin
        t.push_back(CH_SLASH);
        t.push_back(CH_STAR);
        n = $urandom_range(0, 4);
        repeat (n) t.push_back(filler());
        t.push_back(CH_STAR);
        t.push_back(CH_SLASH);
      end else if (kind < 73) begin
        t.push_back(CH_SLASH);
        t.push_back(CH_SLASH);
        n = $urandom_range(0, 4);
        repeat (n) t.push_back(filler());
        t.push_back(CH_NL);
      end else if (kind < 80) begin
        t.push_back($urandom_range(0, 1) ? CH_NL : CH_TAB);
      end else if (kind < 87) begin
        t.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
      end else begin
        t.push_back(8'($urandom_range(0, 255)));
      end
    end
    return t;
  endfunction

  // Stimulus
  initial begin
    text_t t;
    int sent;
    bit paused;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    steady   = 1'b0;
    sent     = 0;
    paused   = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: every delimiter with a space run, comment openers and closers,
    // newline and tab, star slash in plain text, byte extremes
    send_text(to_text("(  ){}[];:=#"));
    send_text(to_text("/*/x*/ "));
    send_text(to_text("//\n\t*/"));
    t = {8'hFF, 8'h00};
    send_text(t);
    drain();

    // random texts
    while (sent < TEXT_ITEMS) begin
      t      = make_text();
      steady = ($urandom_range(0, 5) == 0);
      send_text(t);
      sent += t.size();
      if (!paused && (sent > TEXT_ITEMS / 2)) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if ((sb.errors == 0) && (sb.exp_bytes.size() == 0)) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
